@@ src/delay_embedding_nearest_neighbor_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the delay embedding nearest neighbour unit
// Shared concurrent assertion forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef DELAY_EMBEDDING_NEAREST_NEIGHBOR_UNIT_MACROS_SVH
`define DELAY_EMBEDDING_NEAREST_NEIGHBOR_UNIT_MACROS_SVH

// Same-cycle implication
`define DENN_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define DENN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/denn_pkg.sv @@
// ----------------------------------------------------------------------------
// denn_pkg
// Types and fixed constants of the delay embedding nearest neighbour unit.
// ----------------------------------------------------------------------------
package denn_pkg;

  localparam int IDX_W  = 10;
  localparam int LEN_W  = 11;
  localparam int LAG_W  = 10;
  localparam int VAL_W  = 16;
  localparam int DIM_W  = 5;
  localparam int DIST_W = 16;

  // distance reported when no neighbour qualifies
  localparam logic [DIST_W-1:0] NONE_DISTANCE = 16'hFFFF;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  typedef enum logic {
    CFG_SERIES_LENGTH = 1'b0,
    CFG_LAG           = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP_MUL,
    ST_SETUP_CHECK,
    ST_COPY,
    ST_COPY_WAIT,
    ST_SEARCH,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    kind_t                    kind;
    logic [IDX_W-1:0]         sample_index;
    logic signed [VAL_W-1:0]  sample_value;
    logic [IDX_W-1:0]         query_index;
    logic [DIM_W-1:0]         dimension;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  neighbor_index;
    logic [DIST_W-1:0] distance;
    logic              found;
    logic              bad_query;
  } out_item_t;

endpackage

@@ src/denn_ram.sv @@
// ----------------------------------------------------------------------------
// denn_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module denn_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/delay_embedding_nearest_neighbor_unit.sv @@
// ----------------------------------------------------------------------------
// delay_embedding_nearest_neighbor_unit
// Stores a sample series and finds, for a query vector, the nearest delay
// embedded vector under the max-norm, skipping zero distances.
// ----------------------------------------------------------------------------
// channel | direction | handshake           | beat
// in      | inbound   | in_valid / in_stall | in_item_t (write or query)
// out     | outbound  | out_valid/out_stall | out_item_t (one per query)
// cfg     | inbound   | cfg_valid/cfg_ready | register index and data
//
// A sample write leaves the input free. A query goes from setup through copy,
// search and drain to done (from setup straight to done when rejected or when
// it compares nothing) and compares length - d*lag candidates over d, the
// saturated dimension, components; the input frees once the result is loaded.
// The single store read port sets the pace: one component is compared per cycle.
// Reset (rst, synchronous) clears control and restores length 1024, lag 1; the
// sample store is not cleared. in_stall is high while a query runs; a result that
// finds the previous beat still stalled waits, input too, until out_stall drops.
// ----------------------------------------------------------------------------
module delay_embedding_nearest_neighbor_unit
  import denn_pkg::*;
#(
  parameter int MAX_SAMPLES   = 1024,
  parameter int SAMPLE_BITS   = 16,
  parameter int MAX_DIMENSION = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  cfg_reg_t         cfg_index,
  input  logic [LEN_W-1:0] cfg_data
);

  localparam int MEM_AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int REF_AW = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;
  localparam int DCW    = $clog2(MAX_DIMENSION + 1);
  localparam int SPAN_W = DCW + LAG_W;
  localparam int ACC_W  = SPAN_W + 1;
  localparam int XW     = VAL_W + 1;

  state_t state, state_next;

  // configuration
  logic [LEN_W-1:0] series_length;
  logic [LAG_W-1:0] lag;

  // query context
  logic [IDX_W-1:0]  qi;
  logic [DCW-1:0]    dim;
  logic [LEN_W-1:0]  len;
  logic [SPAN_W-1:0] span;
  logic [LEN_W-1:0]  last_j;
  logic              bad;

  // sequencer counters
  logic [DCW-1:0]   comp;
  logic [LEN_W-1:0] cand;
  logic [ACC_W-1:0] ref_addr;
  logic [ACC_W-1:0] cand_addr;

  // copy and compare pipeline
  logic              copy_v;
  logic [DCW-1:0]    copy_c;
  logic              v1, first1, last1;
  logic [LEN_W-1:0]  j1;
  logic              v2, first2, last2;
  logic [LEN_W-1:0]  j2;
  logic [DIST_W-1:0] diff2;
  logic [DIST_W-1:0] acc;
  logic [DIST_W-1:0] best;
  logic [LEN_W-1:0]  best_j;
  logic              found;

  // memory ports
  logic                   mem_we;
  logic [MEM_AW-1:0]      mem_raddr;
  logic [SAMPLE_BITS-1:0] mem_rdata;
  logic [SAMPLE_BITS-1:0] ref_rdata;

  // combinational helpers
  logic                   comp_last;
  logic                   wr_in_range;
  logic [ACC_W-1:0]       bad_sum;
  logic                   bad_w;
  logic                   nocand_w;
  logic signed [XW-1:0]   xs, ys;
  logic signed [XW:0]     dsub;
  logic [XW:0]            dabs;
  logic [DIST_W-1:0]      m_w;
  logic                   out_free;

  assign cfg_ready   = 1'b1;
  assign comp_last   = (comp == dim - DCW'(1));
  assign wr_in_range = (32'(in_data.sample_index) < MAX_SAMPLES);
  assign out_free    = !out_valid || !out_stall;

  // reference vector checks on the registered span
  assign bad_sum  = ACC_W'(qi) + ACC_W'(span) - ACC_W'(lag);
  assign bad_w    = (dim != '0) && (bad_sum >= ACC_W'(len));
  assign nocand_w = (span >= SPAN_W'(len));

  // absolute difference of the two components arriving from the stores
  assign xs   = XW'(signed'(mem_rdata));
  assign ys   = XW'(signed'(ref_rdata));
  assign dsub = (XW+1)'(xs) - (XW+1)'(ys);
  assign dabs = dsub[XW] ? (XW+1)'(-dsub) : (XW+1)'(dsub);

  // running max-norm of the current candidate
  assign m_w = (first2 || (diff2 > acc)) ? diff2 : acc;

  assign mem_raddr = (state == ST_COPY) ? MEM_AW'(ref_addr) : MEM_AW'(cand_addr);

  denn_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_SAMPLES)
  ) u_sample_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (MEM_AW'(in_data.sample_index)),
    .wdata (SAMPLE_BITS'(in_data.sample_value)),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  denn_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_DIMENSION)
  ) u_ref_ram (
    .clk   (clk),
    .we    (copy_v),
    .waddr (REF_AW'(copy_c)),
    .wdata (mem_rdata),
    .raddr (REF_AW'(comp)),
    .rdata (ref_rdata)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, handshake and store write
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    mem_we     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_data.kind == KIND_QUERY) begin
            state_next = ST_SETUP_MUL;
          end else begin
            mem_we = wr_in_range;
          end
        end
      end
      ST_SETUP_MUL: begin
        state_next = ST_SETUP_CHECK;
      end
      ST_SETUP_CHECK: begin
        if (bad_w || nocand_w || (dim == '0)) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_COPY;
        end
      end
      ST_COPY: begin
        if (comp_last) begin
          state_next = ST_COPY_WAIT;
        end
      end
      ST_COPY_WAIT: begin
        state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (comp_last && (cand == last_j)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v1 && !v2) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      series_length <= LEN_W'(1024);
      lag           <= LAG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SERIES_LENGTH: series_length <= cfg_data;
        CFG_LAG:           lag           <= cfg_data[LAG_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline and output valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      copy_v    <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      copy_v <= (state == ST_COPY);
      v1     <= (state == ST_SEARCH);
      v2     <= v1;
      if ((state == ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // query context, counters and best-so-far
  always_ff @(posedge clk) begin
    // latch the query and saturate dimension and length
    if ((state == ST_IDLE) && in_valid && (in_data.kind == KIND_QUERY)) begin
      qi     <= in_data.query_index;
      dim    <= (32'(in_data.dimension) > MAX_DIMENSION) ? DCW'(MAX_DIMENSION)
                                                         : DCW'(in_data.dimension);
      len    <= (32'(series_length) > MAX_SAMPLES) ? LEN_W'(MAX_SAMPLES)
                                                   : series_length;
      best   <= NONE_DISTANCE;
      best_j <= '0;
      found  <= 1'b0;
    end

    if (state == ST_SETUP_MUL) begin
      span <= SPAN_W'(dim * lag);
    end

    // set up counters for the copy and the sweep
    if (state == ST_SETUP_CHECK) begin
      bad       <= bad_w;
      last_j    <= LEN_W'(SPAN_W'(len) - span - SPAN_W'(1));
      comp      <= '0;
      ref_addr  <= ACC_W'(qi);
      cand      <= '0;
      cand_addr <= '0;
    end

    // copy the reference vector into the small store
    if (state == ST_COPY) begin
      ref_addr <= ref_addr + ACC_W'(lag);
      comp     <= comp_last ? '0 : comp + DCW'(1);
    end
    copy_c <= comp;

    // advance component, then candidate
    if (state == ST_SEARCH) begin
      if (comp_last) begin
        comp      <= '0;
        cand      <= cand + LEN_W'(1);
        cand_addr <= ACC_W'(cand) + ACC_W'(1);
      end else begin
        comp      <= comp + DCW'(1);
        cand_addr <= cand_addr + ACC_W'(lag);
      end
    end
    first1 <= (comp == '0);
    last1  <= comp_last;
    j1     <= cand;

    // register the component difference
    first2 <= first1;
    last2  <= last1;
    j2     <= j1;
    diff2  <= DIST_W'(dabs);

    // fold into the candidate max and keep the earliest smallest nonzero
    if (v2) begin
      acc <= m_w;
      if (last2 && (m_w != '0) && (!found || (m_w < best))) begin
        best   <= m_w;
        best_j <= j2;
        found  <= 1'b1;
      end
    end

    // load the result beat
    if ((state == ST_DONE) && out_free) begin
      out_data.neighbor_index <= best_j[IDX_W-1:0];
      out_data.distance       <= best;
      out_data.found          <= found;
      out_data.bad_query      <= bad;
    end
  end

endmodule

@@ src/denn_checker.sv @@
// ----------------------------------------------------------------------------
// denn_checker
// Port-level checks on the nearest neighbour unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "delay_embedding_nearest_neighbor_unit_macros.svh"

module denn_checker
  import denn_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input in_item_t         in_data,
  input logic             out_valid,
  input logic             out_stall,
  input out_item_t        out_data,
  input logic             cfg_valid,
  input logic             cfg_ready,
  input cfg_reg_t         cfg_index,
  input logic [LEN_W-1:0] cfg_data
);

  logic query_beat;
  logic write_beat;

  assign query_beat = in_valid && !in_stall && (in_data.kind == KIND_QUERY);
  assign write_beat = in_valid && !in_stall && (in_data.kind == KIND_WRITE);

  // a stalled result beat holds
  `DENN_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result beat changed under stall")

  // a query blocks the input while it runs
  `DENN_ASSERT_NEXT(a_query_busy, query_beat, in_stall, "input taken right after a query")

  // a sample write leaves the block ready
  `DENN_ASSERT_NEXT(a_write_ready, write_beat, !in_stall, "block busy after a sample write")

  // a not-found result carries the sentinel
  `DENN_ASSERT_NOW(a_none_sentinel, out_valid && !out_data.found, (out_data.distance == NONE_DISTANCE) && (out_data.neighbor_index == '0), "not-found result without sentinel")

  // a bad reference vector never reports a neighbour
  `DENN_ASSERT_NOW(a_bad_not_found, out_valid && out_data.bad_query, !out_data.found, "bad query reported a neighbour")

endmodule

bind delay_embedding_nearest_neighbor_unit denn_checker u_denn_checker (.*);

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: delay embedding nearest neighbour unit testbench
// Loads the sample store, sweeps length and lag settings and drives writes
// and queries. A behavioural nearest neighbour search predicts each result,
// and every result beat is checked field by field, in order, against it.
// ----------------------------------------------------------------------------
module tb_top;
  import denn_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH = 1024;
  localparam int FILL_DEPTH  = 32;
  localparam int DIM_LIMIT   = 16;
  localparam int HOLD_CYCLES = 600;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  cfg_reg_t         cfg_index;
  logic [LEN_W-1:0] cfg_data;

  // testbench copy of the block's state
  logic signed [VAL_W-1:0] series_copy [STORE_DEPTH];
  int                      series_len = 1024;
  int                      lag_reg    = 1;
  out_item_t               pending_results [$];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_req      = 1'b0;
  int  hold_left     = 0;
  int  errors        = 0;
  int  n_writes      = 0;
  int  n_queries     = 0;
  int  n_checked     = 0;
  int  n_found       = 0;
  int  n_bad         = 0;

  delay_embedding_nearest_neighbor_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous limit: the slowest correct run is far below this
  initial begin
    #30_000_000;
    $display("delay_embedding_nearest_neighbor_unit test failed");
    $finish;
  end

  // Chebyshev nearest neighbour over the lagged vectors, zero distances skipped
  function automatic out_item_t nearest_neighbour(input int qi, input int dim);
    int        n, d, limit, j, c, vec_dist, diff, best_d, best_j;
    bit        hit, bad;
    out_item_t res;
    d      = (dim > DIM_LIMIT) ? DIM_LIMIT : dim;
    n      = (series_len > STORE_DEPTH) ? STORE_DEPTH : series_len;
    bad    = (d >= 1) && (qi + (d - 1) * lag_reg >= n);
    hit    = 1'b0;
    best_d = 0;
    best_j = 0;
    if (!bad && d * lag_reg < n) begin
      limit = n - d * lag_reg;
      for (j = 0; j < limit; j++) begin
        vec_dist = 0;
        for (c = 0; c < d; c++) begin
          diff = int'(series_copy[(qi + c * lag_reg) % STORE_DEPTH])
               - int'(series_copy[(j + c * lag_reg) % STORE_DEPTH]);
          if (diff < 0) diff = -diff;
          if (diff > vec_dist) vec_dist = diff;
        end
        // strict less-than keeps the earliest candidate on a tie
        if (vec_dist != 0 && (!hit || vec_dist < best_d)) begin
          hit    = 1'b1;
          best_d = vec_dist;
          best_j = j;
        end
      end
    end
    res.neighbor_index = hit ? best_j[IDX_W-1:0] : '0;
    res.distance       = hit ? best_d[DIST_W-1:0] : NONE_DISTANCE;
    res.found          = hit;
    res.bad_query      = bad;
    return res;
  endfunction

  function automatic void report_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Hold the output for a long stretch on request, otherwise stall at random
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        report_field("neighbor_index", 16'(want.neighbor_index),
                     16'(out_data.neighbor_index));
        report_field("distance", want.distance, out_data.distance);
        report_field("found", 16'(want.found), 16'(out_data.found));
        report_field("bad_query", 16'(want.bad_query), 16'(out_data.bad_query));
        n_checked++;
        if (want.found) n_found++;
        if (want.bad_query) n_bad++;
      end
    end
  end

  // Offer one beat, with random idle cycles ahead of it, and predict on acceptance
  task automatic send_item(input in_item_t item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    if (item.kind == KIND_WRITE) begin
      series_copy[item.sample_index] = item.sample_value;
      n_writes++;
    end else begin
      pending_results = {pending_results,
                         nearest_neighbour(int'(item.query_index), int'(item.dimension))};
      n_queries++;
    end
  endtask

  task automatic write_sample(input int idx, input int val);
    in_item_t item;
    item.kind         = KIND_WRITE;
    item.sample_index = idx[IDX_W-1:0];
    item.sample_value = val[VAL_W-1:0];
    item.query_index  = IDX_W'($urandom_range(0, 1023));
    item.dimension    = DIM_W'($urandom_range(0, 31));
    send_item(item);
  endtask

  task automatic run_query(input int qi, input int dim);
    in_item_t item;
    item.kind         = KIND_QUERY;
    item.sample_index = IDX_W'($urandom_range(0, 1023));
    item.sample_value = VAL_W'($urandom_range(0, 65535));
    item.query_index  = qi[IDX_W-1:0];
    item.dimension    = dim[DIM_W-1:0];
    send_item(item);
  endtask

  // Drop valid and wait until every predicted result has arrived
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write both registers while the block is idle
  task automatic set_config(input int length, input int lag_word);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_SERIES_LENGTH;
    cfg_data  <= length[LEN_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    series_len = int'(length[LEN_W-1:0]);
    cfg_index <= CFG_LAG;
    cfg_data  <= lag_word[LEN_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    lag_reg = int'(lag_word[LAG_W-1:0]);
    cfg_valid <= 1'b0;
  endtask

  // Load the low store entries
  task automatic test_fill_store();
    int i;
    for (i = 0; i < FILL_DEPTH; i++) write_sample(i, int'($urandom_range(0, 65535)));
  endtask

  // Queries at the reset settings: full length, lag 1; all but the first are
  // rejected or compare nothing
  task automatic test_reset_settings();
    run_query(1000, 16);
    run_query(1009, 16);
    run_query(1020, 31);
    run_query(7, 0);
    run_query(1023, 2);
  endtask

  // Extreme sample values, ties, exact duplicates and a saturated dimension
  task automatic test_extreme_values();
    int i;
    set_config(3, 1);
    write_sample(0, -32768);
    write_sample(1, 32767);
    write_sample(2, -32768);
    run_query(1, 1);
    run_query(0, 1);
    set_config(6, 1);
    write_sample(0, 0);
    write_sample(1, 2);
    write_sample(2, -2);
    write_sample(3, 0);
    write_sample(4, 7);
    write_sample(5, 2);
    run_query(0, 1);
    run_query(4, 1);
    set_config(4, 1);
    for (i = 0; i < 4; i++) write_sample(i, 3);
    run_query(0, 1);
    run_query(1, 2);
    set_config(20, 1);
    run_query(2, 20);
  endtask

  // Zero length and lengths past the store size
  task automatic test_length_limits();
    set_config(0, 1);
    run_query(0, 1);
    run_query(0, 0);
    set_config(2047, 'h3FF);
    run_query(5, 1);
    run_query(0, 2);
    run_query(1, 2);
    set_config(1025, 1);
    run_query(1021, 4);
  endtask

  // Lag zero, a lag word with its spare bit set, and too few candidates
  task automatic test_lag_cases();
    set_config(16, 0);
    run_query(2, 3);
    run_query(15, 16);
    set_config(16, 'h402);
    run_query(1, 4);
    run_query(9, 4);
    set_config(8, 2);
    run_query(0, 4);
    set_config(12, 1023);
    run_query(0, 1);
    run_query(0, 2);
  endtask

  // Hold the output long enough that the block fills and stalls its input
  task automatic test_back_pressure();
    int k;
    set_config(24, 1);
    hold_req = 1'b1;
    for (k = 0; k < 8; k++) begin
      if (k == 3) write_sample(int'($urandom_range(0, 23)), int'($urandom_range(0, 8)) - 4);
      else run_query(int'($urandom_range(0, 22)), 2);
    end
    wait_idle();
  endtask

  // Random segments: pick settings, then mostly well-formed writes and queries
  task automatic test_random(input int count);
    int i, seg, pick, n, lg, d, maxd, span, qi, idx, val;
    i = 0;
    while (i < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) n = $urandom_range(8, FILL_DEPTH);
      else n = $urandom_range(0, 7);
      pick = $urandom_range(0, 99);
      if (pick < 70) lg = $urandom_range(1, 3);
      else if (pick < 85) lg = $urandom_range(4, 12);
      else if (pick < 95) lg = 0;
      else lg = $urandom_range(0, 1023);
      set_config(n, (int'($urandom_range(0, 1)) << LAG_W) + lg);
      for (seg = 0; seg < 12 && i < count; seg++) begin
        i++;
        if ($urandom_range(0, 99) < 40) begin
          if (n > 0 && $urandom_range(0, 99) < 85) idx = $urandom_range(0, n - 1);
          else idx = $urandom_range(0, 1023);
          pick = $urandom_range(0, 99);
          if (pick < 60) val = int'($urandom_range(0, 8)) - 4;
          else if (pick < 85) val = $urandom_range(0, 65535);
          else if (pick < 93) val = -32768;
          else val = 32767;
          write_sample(idx, val);
        end else if ($urandom_range(0, 99) < 85) begin
          // keep the reference vector and every candidate inside the series
          maxd = (lg == 0) ? DIM_LIMIT : (n - 1) / lg;
          if (maxd > DIM_LIMIT) maxd = DIM_LIMIT;
          if (maxd < 1) maxd = 1;
          d    = ($urandom_range(0, 99) < 8) ? 0 : $urandom_range(1, maxd);
          span = (d == 0) ? 0 : (d - 1) * lg;
          qi   = (n - 1 - span >= 0) ? $urandom_range(0, n - 1 - span) : 0;
          run_query(qi, d);
        end else begin
          run_query(int'($urandom_range(0, 1023)), int'($urandom_range(0, 31)));
        end
      end
    end
  endtask

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_SERIES_LENGTH;
    cfg_data  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // sender rarely idles, receiver mostly stalls
    send_idle_pct = 7;
    recv_idle_pct = 82;
    test_fill_store();
    test_reset_settings();
    test_extreme_values();
    test_length_limits();
    test_lag_cases();
    test_random(12);

    // the other way round
    send_idle_pct = 82;
    recv_idle_pct = 7;
    test_random(12);

    // no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(12);
    test_back_pressure();

    wait_idle();
    repeat (100) @(posedge clk);
    $display("Ran %0d sample writes and %0d queries; %0d results checked, %0d found, %0d bad.",
             n_writes, n_queries, n_checked, n_found, n_bad);
    $display("Lengths 0 to 2047 and lags 0 to 1023, under idling, stalls and a long hold.");
    if (errors == 0) begin
      $display("delay_embedding_nearest_neighbor_unit test passed");
    end else begin
      $display("delay_embedding_nearest_neighbor_unit test failed");
    end
    $finish;
  end

endmodule

@@ delay_embedding_nearest_neighbor_unit.f @@
+incdir+src
src/denn_pkg.sv
src/denn_ram.sv
src/delay_embedding_nearest_neighbor_unit.sv
src/denn_checker.sv
sim/tb_top.sv
